@@ rtl/lqt_pkg.sv @@
// Shared types and codes of the link quality table.
package lqt_pkg;

  typedef logic [15:0] addr_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_CONTAINER = 2'd1;
  localparam logic [1:0] ST_LIST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND    = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    addr_t      container_addr;
    addr_t      neighbour_addr;
    logic [7:0] quality_in;
    logic       neighbour_known;
  } in_item_t;

  typedef struct packed {
    logic [7:0] quality_out;
    logic [5:0] containers_in_use;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    addr_t      neighbour;
    logic [7:0] quality;
  } link_word_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CSCAN,
    FSM_LSCAN
  } fsm_t;

endpackage

@@ rtl/lqt_cont_mem.sv @@
// Container store: key and link count per container, with per-entry valid bits.
module lqt_cont_mem #(
  parameter int DEPTH = 32,
  parameter int CNT_W = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  lqt_pkg::addr_t                        wkey,
  input  logic [CNT_W-1:0]                      wcount,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output lqt_pkg::addr_t                        rkey,
  output logic [CNT_W-1:0]                      rcount
);

  lqt_pkg::addr_t   key_mem [DEPTH];
  logic [CNT_W-1:0] cnt_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic             rvld_r;
  lqt_pkg::addr_t   rkey_r;
  logic [CNT_W-1:0] rcnt_r;

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      cnt_mem[waddr] <= wcount;
    end
    rkey_r <= key_mem[raddr];
    rcnt_r <= cnt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  // an entry never written reads as empty
  assign rkey   = rvld_r ? rkey_r : '0;
  assign rcount = rvld_r ? rcnt_r : '0;

endmodule

@@ rtl/lqt_link_mem.sv @@
// Link store: neighbour address and quality per slot, one write and one read port.
module lqt_link_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  lqt_pkg::link_word_t                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output lqt_pkg::link_word_t                        rdata
);

  lqt_pkg::link_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/link_quality_table.sv @@
// Top level of the link quality table: command sequencer around two memories.
//
// Input channel: in_item is taken at a rising edge with start high and busy
// low. Clear-all completes at once and leaves busy low. Any other command
// raises busy while the sequencer walks the container store, one container a
// cycle, and then, if the command needs it, the link list of the chosen
// container, one link a cycle. No item is taken while busy. The container
// scan compares 1 to NUM_CONTAINERS containers and the link scan 0 to
// LINKS_PER_CONTAINER links; the walk is sequential because each memory
// has a single read port.
// Result channel: exactly one word per item, on out_item with out_valid high
// for one cycle, in the cycle after the last scan step or, for clear-all,
// the accepting step. The receiver cannot stall; a word not taken is lost.
// Configuration: cfg_data sets coordinator mode when cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// Reset: synchronous, active low. Coordinator mode is set, the container
// count and the container valid bits clear at once; no clearing pass runs.
module link_quality_table #(
  parameter int NUM_CONTAINERS      = 32,
  parameter int LINKS_PER_CONTAINER = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lqt_pkg::in_item_t    in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  output logic                 out_valid,
  output lqt_pkg::out_item_t   out_item
);

  localparam int CW    = NUM_CONTAINERS > 1 ? $clog2(NUM_CONTAINERS) : 1;
  localparam int UW    = $clog2(NUM_CONTAINERS + 1);
  localparam int NW    = $clog2(LINKS_PER_CONTAINER + 1);
  localparam int SLOTS = NUM_CONTAINERS * LINKS_PER_CONTAINER;
  localparam int AW    = SLOTS > 1 ? $clog2(SLOTS) : 1;

  lqt_pkg::fsm_t      state_r, state_nxt;
  lqt_pkg::in_item_t  item_r, item_nxt;
  logic               mode_r;
  logic [UW-1:0]      used_r, used_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      c_r, c_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [NW-1:0]      j_r, j_nxt;
  logic               out_valid_r;
  lqt_pkg::out_item_t out_item_r;

  // memory ports
  logic                cwe;
  logic [CW-1:0]       cwaddr, craddr;
  logic [NW-1:0]       cwcount;
  lqt_pkg::addr_t      crkey;
  logic [NW-1:0]       crcount;
  logic                lwe;
  logic [AW-1:0]       lwaddr, lraddr;
  lqt_pkg::link_word_t lwdata, lrdata;

  // scan decisions
  logic [1:0]    cmd;
  logic          cont_hit, cont_more, can_open, open_c, have_c, go_lscan;
  logic [CW-1:0] sel_c;
  logic [NW-1:0] sel_n;
  logic          link_hit, link_more;

  // result of this cycle
  logic       done_c;
  logic [1:0] status_c;
  logic [7:0] qual_c;

  function automatic logic [AW-1:0] link_base(input logic [CW-1:0] c);
    return AW'(c) * AW'(LINKS_PER_CONTAINER);
  endfunction

  lqt_cont_mem #(
    .DEPTH (NUM_CONTAINERS),
    .CNT_W (NW)
  ) u_cont_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (cwe),
    .waddr  (cwaddr),
    .wkey   (item_r.container_addr),
    .wcount (cwcount),
    .raddr  (craddr),
    .rkey   (crkey),
    .rcount (crcount)
  );

  lqt_link_mem #(
    .DEPTH (SLOTS)
  ) u_link_mem (
    .clk   (clk),
    .we    (lwe),
    .waddr (lwaddr),
    .wdata (lwdata),
    .raddr (lraddr),
    .rdata (lrdata)
  );

  always_comb begin
    cmd       = item_r.command;
    // peer mode always lands on container zero
    cont_hit  = !mode_r ||
                ((UW'(idx_r) < used_r) && (crkey == item_r.container_addr));
    cont_more = mode_r && ((UW'(idx_r) + UW'(1)) < used_r);
    can_open  = used_r < UW'(NUM_CONTAINERS);
    open_c    = !cont_hit && !cont_more && (cmd != lqt_pkg::CMD_QUERY) && can_open;
    have_c    = cont_hit || open_c;
    sel_c     = cont_hit ? idx_r : CW'(used_r);
    sel_n     = cont_hit ? crcount : '0;
    go_lscan  = ((cmd == lqt_pkg::CMD_QUERY) ||
                 ((cmd == lqt_pkg::CMD_INSERT) && item_r.neighbour_known)) &&
                (sel_n != '0);
    link_hit  = lrdata.neighbour == item_r.neighbour_addr;
    link_more = (j_r + NW'(1)) < n_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lqt_pkg::FSM_IDLE: begin
        if (start && (in_item.command != lqt_pkg::CMD_CLEAR)) begin
          state_nxt = lqt_pkg::FSM_CSCAN;
        end
      end
      lqt_pkg::FSM_CSCAN: begin
        if (have_c) begin
          state_nxt = go_lscan ? lqt_pkg::FSM_LSCAN : lqt_pkg::FSM_IDLE;
        end else if (!cont_more) begin
          state_nxt = lqt_pkg::FSM_IDLE;
        end
      end
      lqt_pkg::FSM_LSCAN: begin
        if (link_hit || !link_more) begin
          state_nxt = lqt_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = lqt_pkg::FSM_IDLE;
    endcase
  end

  // memory accesses, scan registers and result
  always_comb begin
    done_c   = 1'b0;
    status_c = lqt_pkg::ST_OK;
    qual_c   = '0;
    cwe      = 1'b0;
    cwaddr   = c_r;
    cwcount  = n_r;
    craddr   = '0;
    lwe      = 1'b0;
    lwaddr   = '0;
    lwdata   = '{neighbour: item_r.neighbour_addr, quality: item_r.quality_in};
    lraddr   = '0;
    item_nxt = item_r;
    used_nxt = used_r;
    idx_nxt  = idx_r;
    c_nxt    = c_r;
    n_nxt    = n_r;
    j_nxt    = j_r;
    case (state_r)
      lqt_pkg::FSM_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          idx_nxt  = '0;
          if (in_item.command == lqt_pkg::CMD_CLEAR) begin
            done_c   = 1'b1;
            used_nxt = mode_r ? '0 : UW'(1);
          end else if (!mode_r) begin
            used_nxt = UW'(1);
          end
        end
      end
      lqt_pkg::FSM_CSCAN: begin
        c_nxt = sel_c;
        n_nxt = sel_n;
        j_nxt = '0;
        if (have_c) begin
          cwaddr  = sel_c;
          cwcount = sel_n;
          if (open_c) begin
            used_nxt = used_r + UW'(1);
          end
          case (cmd)
            lqt_pkg::CMD_QUERY: begin
              if (sel_n == '0) begin
                done_c   = 1'b1;
                status_c = lqt_pkg::ST_NOT_FOUND;
              end else begin
                lraddr = link_base(sel_c);
              end
            end
            lqt_pkg::CMD_RESET: begin
              done_c  = 1'b1;
              cwe     = 1'b1;
              cwcount = '0;
            end
            lqt_pkg::CMD_INSERT: begin
              if (!item_r.neighbour_known) begin
                done_c = 1'b1;
                cwe    = 1'b1;
              end else if (sel_n == '0) begin
                // empty list: append at the first slot straight away
                done_c  = 1'b1;
                cwe     = 1'b1;
                cwcount = NW'(1);
                lwe     = 1'b1;
                lwaddr  = link_base(sel_c);
              end else begin
                lraddr = link_base(sel_c);
              end
            end
            default: ;
          endcase
        end else if (cont_more) begin
          idx_nxt = idx_r + CW'(1);
          craddr  = idx_r + CW'(1);
        end else begin
          done_c   = 1'b1;
          status_c = (cmd == lqt_pkg::CMD_QUERY) ? lqt_pkg::ST_NOT_FOUND
                                                 : lqt_pkg::ST_NO_CONTAINER;
        end
      end
      lqt_pkg::FSM_LSCAN: begin
        if (link_hit) begin
          done_c = 1'b1;
          if (cmd == lqt_pkg::CMD_QUERY) begin
            qual_c = lrdata.quality;
          end else begin
            cwe    = 1'b1;
            lwe    = 1'b1;
            lwaddr = link_base(c_r) + AW'(j_r);
          end
        end else if (link_more) begin
          j_nxt  = j_r + NW'(1);
          lraddr = link_base(c_r) + AW'(j_r + NW'(1));
        end else begin
          done_c = 1'b1;
          if (cmd == lqt_pkg::CMD_QUERY) begin
            status_c = lqt_pkg::ST_NOT_FOUND;
          end else if (n_r >= NW'(LINKS_PER_CONTAINER)) begin
            status_c = lqt_pkg::ST_LIST_FULL;
            cwe      = 1'b1;
          end else begin
            cwe     = 1'b1;
            cwcount = n_r + NW'(1);
            lwe     = 1'b1;
            lwaddr  = link_base(c_r) + AW'(n_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lqt_pkg::FSM_IDLE;
      mode_r      <= 1'b1;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= done_c;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    c_r    <= c_nxt;
    n_r    <= n_nxt;
    j_r    <= j_nxt;
    if (done_c) begin
      out_item_r <= '{quality_out:       qual_c,
                      containers_in_use: 6'(used_nxt),
                      status:            status_c};
    end
  end

  // writes land only on the finishing step, with busy still high, so no
  // read of the next word can meet them
  assign busy      = state_r != lqt_pkg::FSM_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
